// ----- rtl/rlts_pkg.sv -----
// Shared constants, types and the turn circumference table for roll_lift_to_steps.
package rlts_pkg;

  localparam int unsigned TURN_ENTRIES = 14;
  localparam int unsigned TABLE_CAP    = 32;
  localparam int unsigned TABLE_IDX_W  = $clog2(TABLE_CAP);
  localparam int unsigned TURN_IDX_W   = $clog2(TURN_ENTRIES);
  localparam int unsigned TURN_CNT_W   = $clog2(TURN_ENTRIES + 1);

  localparam int unsigned LIFT_W  = 16;
  localparam int unsigned STEPS_W = 24;
  localparam int unsigned SPT_W   = 16;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned CFG_IDX_W = 2;

  // Circumferences in tenths of a mm stay below 2048.
  localparam int unsigned CIRC_W  = 11;
  // lift * 10 stays below 2**20.
  localparam int unsigned REM_W   = 20;
  localparam int unsigned PROD_W  = SPT_W + CIRC_W;
  localparam int unsigned QUO_W   = SPT_W;
  localparam int unsigned WHOLE_W = SPT_W + TURN_CNT_W;

  localparam logic [LIFT_W-1:0]  MAX_LIFT_RST = 16'd1600;
  localparam logic [STEPS_W-1:0] MAX_STEPS_RST = 24'd156000;
  localparam logic [SPT_W-1:0]   SPT_RST = 16'd12000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_LIFT  = 2'd0,
    CFG_MAX_STEPS = 2'd1,
    CFG_SPT       = 2'd2
  } cfg_idx_e;

  localparam logic [CIRC_W-1:0] CIRC_TABLE [TABLE_CAP] = '{
    11'd0,    11'd1013, 11'd1059, 11'd1089, 11'd1124, 11'd1158, 11'd1186, 11'd1219,
    11'd1255, 11'd1284, 11'd1321, 11'd1350, 11'd1387, 11'd1419, 11'd0,    11'd0,
    11'd0,    11'd0,    11'd0,    11'd0,    11'd0,    11'd0,    11'd0,    11'd0,
    11'd0,    11'd0,    11'd0,    11'd0,    11'd0,    11'd0,    11'd0,    11'd0
  };

  function automatic logic [CIRC_W-1:0] circ_at(input logic [TURN_IDX_W-1:0] idx);
    return CIRC_TABLE[TABLE_IDX_W'(idx)];
  endfunction

endpackage

// ----- rtl/rlts_div.sv -----
// Restoring divider: one quotient bit per cycle, quotient known to fit QUO_W bits.
module rlts_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rlts_pkg::PROD_W-1:0] num_i,
  input  logic [rlts_pkg::CIRC_W-1:0] den_i,
  output logic                       done_o,
  output logic [rlts_pkg::QUO_W-1:0]  quo_o
);

  localparam int unsigned CNT_W = $clog2(rlts_pkg::QUO_W + 1);

  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic                          done_q, done_d;
  logic [rlts_pkg::CIRC_W-1:0]   part_q, part_d;
  logic [rlts_pkg::CIRC_W-1:0]   den_q, den_d;
  logic [rlts_pkg::QUO_W-1:0]    num_q, num_d;
  logic [rlts_pkg::QUO_W-1:0]    quo_q, quo_d;
  logic [rlts_pkg::CIRC_W:0]     trial;
  logic [rlts_pkg::CIRC_W:0]     diff;
  logic                          qbit;

  assign trial = {part_q, num_q[rlts_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign qbit  = (trial >= {1'b0, den_q});

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    part_d = part_q;
    den_d  = den_q;
    num_d  = num_q;
    quo_d  = quo_q;
    if (start_i) begin
      // High bits of the dividend are below the divisor, so seed with them.
      part_d = num_i[rlts_pkg::PROD_W-1:rlts_pkg::QUO_W];
      num_d  = num_i[rlts_pkg::QUO_W-1:0];
      den_d  = den_i;
      cnt_d  = CNT_W'(rlts_pkg::QUO_W);
    end else if (cnt_q != '0) begin
      part_d = qbit ? diff[rlts_pkg::CIRC_W-1:0] : trial[rlts_pkg::CIRC_W-1:0];
      num_d  = {num_q[rlts_pkg::QUO_W-2:0], 1'b0};
      quo_d  = {quo_q[rlts_pkg::QUO_W-2:0], qbit};
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    part_q <= part_d;
    den_q  <= den_d;
    num_q  <= num_d;
    quo_q  <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- rtl/roll_lift_to_steps_top.sv -----
// Top level: lift in mm to stepper steps through a table walk and a restoring divider.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  input   | in_valid_i, in_stall_o, lift_mm_i    | in
//  output  | out_valid_o, out_stall_i, steps_o,   | out
//          | clamped_o                            |
//  config  | cfg_we_i, cfg_index_i, cfg_data_i    | in
//
// A transaction clamped on range goes from the accept straight to the done state, one
// that runs past the table clamps after the whole walk. Otherwise the walk compares
// the table entries (2 to TURN_ENTRIES), one entry per cycle through the compare/subtract,
// then come one multiply, a divider start and 16 divider steps up to the done strobe.
// in_stall_o is high while a transaction is in work; a finished result waits in
// the output register while out_stall_i is high. Reset loads the register defaults.
module roll_lift_to_steps_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [rlts_pkg::LIFT_W-1:0]    lift_mm_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [rlts_pkg::STEPS_W-1:0]   steps_o,
  output logic                           clamped_o,
  input  logic                           cfg_we_i,
  input  logic [rlts_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rlts_pkg::CFG_W-1:0]     cfg_data_i
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_WALK   = 6'b000010,
    ST_MUL    = 6'b000100,
    ST_DSTART = 6'b001000,
    ST_DWAIT  = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [rlts_pkg::LIFT_W-1:0]  max_lift_q;
  logic [rlts_pkg::STEPS_W-1:0] max_steps_q;
  logic [rlts_pkg::SPT_W-1:0]   spt_q;

  logic [rlts_pkg::TURN_CNT_W-1:0] cnt_q, cnt_d;
  logic [rlts_pkg::REM_W-1:0]      rem_q, rem_d;
  logic [rlts_pkg::WHOLE_W-1:0]    whole_q, whole_d;
  logic [rlts_pkg::CIRC_W-1:0]     circ_q, circ_d;
  logic [rlts_pkg::PROD_W-1:0]     prod_q, prod_d;
  logic [rlts_pkg::STEPS_W-1:0]    res_steps_q, res_steps_d;
  logic                            res_clamp_q, res_clamp_d;
  logic                            out_valid_q, out_valid_d;
  logic [rlts_pkg::STEPS_W-1:0]    out_steps_q, out_steps_d;
  logic                            out_clamp_q, out_clamp_d;

  logic [rlts_pkg::CIRC_W-1:0]     circ_cur;
  logic [rlts_pkg::REM_W-1:0]      circ_ext;
  logic                            in_acc;
  logic                            div_start;
  logic                            div_done;
  logic [rlts_pkg::QUO_W-1:0]      div_quo;
  logic [rlts_pkg::WHOLE_W:0]      total;

  assign circ_cur = rlts_pkg::circ_at(cnt_q[rlts_pkg::TURN_IDX_W-1:0]);
  assign circ_ext = rlts_pkg::REM_W'(circ_cur);
  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign div_start = (state_q == ST_DSTART);
  assign total = {1'b0, whole_q} + (rlts_pkg::WHOLE_W + 1)'(div_quo);

  rlts_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_q),
    .den_i   (circ_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_lift_q  <= rlts_pkg::MAX_LIFT_RST;
      max_steps_q <= rlts_pkg::MAX_STEPS_RST;
      spt_q       <= rlts_pkg::SPT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rlts_pkg::CFG_MAX_LIFT:  max_lift_q  <= cfg_data_i[rlts_pkg::LIFT_W-1:0];
        rlts_pkg::CFG_MAX_STEPS: max_steps_q <= cfg_data_i[rlts_pkg::STEPS_W-1:0];
        rlts_pkg::CFG_SPT:       spt_q       <= cfg_data_i[rlts_pkg::SPT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    whole_d     = whole_q;
    circ_d      = circ_q;
    prod_d      = prod_q;
    res_steps_d = res_steps_q;
    res_clamp_d = res_clamp_q;
    out_valid_d = out_valid_q;
    out_steps_d = out_steps_q;
    out_clamp_d = out_clamp_q;

    // Drop the output once taken.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cnt_d   = '0;
          whole_d = '0;
          // lift * 10 as two shifts
          rem_d   = (rlts_pkg::REM_W'(lift_mm_i) << 3)
                  + (rlts_pkg::REM_W'(lift_mm_i) << 1);
          if (lift_mm_i > max_lift_q) begin
            res_steps_d = max_steps_q;
            res_clamp_d = 1'b1;
            state_d     = ST_DONE;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (cnt_q == rlts_pkg::TURN_CNT_W'(rlts_pkg::TURN_ENTRIES)) begin
          // Ran past the table: clamp.
          res_steps_d = max_steps_q;
          res_clamp_d = 1'b1;
          state_d     = ST_DONE;
        end else if (rem_q < circ_ext) begin
          circ_d  = circ_cur;
          state_d = ST_MUL;
        end else begin
          rem_d   = rem_q - circ_ext;
          whole_d = whole_q + rlts_pkg::WHOLE_W'(spt_q);
          cnt_d   = cnt_q + rlts_pkg::TURN_CNT_W'(1);
        end
      end
      ST_MUL: begin
        prod_d  = rlts_pkg::PROD_W'(spt_q) * rlts_pkg::PROD_W'(rem_q[rlts_pkg::CIRC_W-1:0]);
        state_d = ST_DSTART;
      end
      ST_DSTART: begin
        state_d = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) begin
          res_steps_d = rlts_pkg::STEPS_W'(total);
          res_clamp_d = 1'b0;
          state_d     = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_steps_d = res_steps_q;
          out_clamp_d = res_clamp_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q       <= cnt_d;
    rem_q       <= rem_d;
    whole_q     <= whole_d;
    circ_q      <= circ_d;
    prod_q      <= prod_d;
    res_steps_q <= res_steps_d;
    res_clamp_q <= res_clamp_d;
    out_steps_q <= out_steps_d;
    out_clamp_q <= out_clamp_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign steps_o     = out_steps_q;
  assign clamped_o   = out_clamp_q;

endmodule

// ----- tb/tb_roll_lift_to_steps_top.sv -----
// Self-checking testbench for roll_lift_to_steps_top: lift in mm against predicted step counts.
`timescale 1ns / 1ps

module tb_roll_lift_to_steps_top;

  typedef struct packed {
    logic [rlts_pkg::STEPS_W-1:0] steps;
    logic                         clamped;
  } lift_steps_t;

  localparam int unsigned CIRC_LIST [14] = '{
    0, 1013, 1059, 1089, 1124, 1158, 1186, 1219, 1255, 1284, 1321, 1350, 1387, 1419
  };

  logic                           clk;
  logic                           rst_n       = 1'b0;
  logic                           in_valid    = 1'b0;
  logic                           in_stall;
  logic [rlts_pkg::LIFT_W-1:0]    lift_mm     = '0;
  logic                           out_valid;
  logic                           rx_stall    = 1'b0;
  logic                           hold_stall  = 1'b0;
  logic                           out_stall;
  logic [rlts_pkg::STEPS_W-1:0]   steps;
  logic                           clamped;
  logic                           cfg_we      = 1'b0;
  logic [rlts_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
  logic [rlts_pkg::CFG_W-1:0]     cfg_data    = '0;

  // Register shadow for the predictor
  logic [rlts_pkg::LIFT_W-1:0]  shadow_max_lift  = rlts_pkg::MAX_LIFT_RST;
  logic [rlts_pkg::STEPS_W-1:0] shadow_max_steps = rlts_pkg::MAX_STEPS_RST;
  logic [rlts_pkg::SPT_W-1:0]   shadow_spt       = rlts_pkg::SPT_RST;

  lift_steps_t steps_due[$];
  int unsigned err_cnt = 0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;

  assign out_stall = rx_stall | hold_stall;

  roll_lift_to_steps_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .lift_mm_i   (lift_mm),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .steps_o     (steps),
    .clamped_o   (clamped),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic longint unsigned turn_circ(input int unsigned n);
    if (n < 14) begin
      return CIRC_LIST[n];
    end
    return 0;
  endfunction

  function automatic lift_steps_t calc_lift_steps(input logic [rlts_pkg::LIFT_W-1:0] lift);
    lift_steps_t       res;
    longint unsigned   rest;
    longint unsigned   circ;
    longint unsigned   spt;
    res.steps   = shadow_max_steps;
    res.clamped = 1'b1;
    spt         = shadow_spt;
    if (lift > shadow_max_lift) begin
      return res;
    end
    rest = longint'(lift) * 10;
    for (int unsigned n = 0; n < rlts_pkg::TURN_ENTRIES; n++) begin
      circ = turn_circ(n);
      if (rest < circ) begin
        res.steps   = rlts_pkg::STEPS_W'(spt * n + (spt * rest) / circ);
        res.clamped = 1'b0;
        return res;
      end
      rest -= circ;
    end
    return res;
  endfunction

  // Mostly in-range lifts, with turn boundaries and the clamp edge weighted up
  function automatic logic [rlts_pkg::LIFT_W-1:0] pick_lift();
    int unsigned     sel;
    int unsigned     k;
    longint unsigned sum;
    longint          val;
    sel = $urandom_range(0, 9);
    sum = 0;
    if (sel <= 5) begin
      return rlts_pkg::LIFT_W'($urandom_range(0, 1700));
    end else if (sel <= 7) begin
      k = $urandom_range(0, 13);
      for (int unsigned n = 0; n <= k; n++) begin
        sum += turn_circ(n);
      end
      val = longint'(sum / 10) + $urandom_range(0, 2) - 1;
    end else if (sel == 8) begin
      val = longint'(shadow_max_lift) + $urandom_range(0, 4) - 2;
    end else begin
      return rlts_pkg::LIFT_W'($urandom_range(0, 65535));
    end
    if (val < 0) val = 0;
    if (val > 65535) val = 65535;
    return rlts_pkg::LIFT_W'(val);
  endfunction

  task automatic write_reg(input rlts_pkg::cfg_idx_e idx,
                           input logic [rlts_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rlts_pkg::CFG_MAX_LIFT:  shadow_max_lift  = data[rlts_pkg::LIFT_W-1:0];
      rlts_pkg::CFG_MAX_STEPS: shadow_max_steps = data[rlts_pkg::STEPS_W-1:0];
      rlts_pkg::CFG_SPT:       shadow_spt       = data[rlts_pkg::SPT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_lift(input logic [rlts_pkg::LIFT_W-1:0] lift);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    lift_mm  <= lift;
    do @(posedge clk); while (in_stall);
    steps_due.push_back(calc_lift_steps(lift));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (steps_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic hold_output(input int unsigned cycles);
    hold_stall <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_stall <= 1'b0;
  endtask

  // Receiver: while rx_idle is set, pause a random number of cycles after each accepted result
  initial begin
    int unsigned wait_n;
    forever begin
      wait_n = rx_idle ? $urandom_range(0, 11) : 0;
      if (wait_n != 0) begin
        rx_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      rx_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin : check_results
    lift_steps_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (steps_due.size() == 0) begin
        if (err_cnt < 10) begin
          $display("unexpected result: steps=%0d clamped=%0b", steps, clamped);
        end
        err_cnt++;
      end else begin
        want = steps_due.pop_front();
        if (steps !== want.steps || clamped !== want.clamped) begin
          if (err_cnt < 10) begin
            $display("mismatch: expected steps=%0d clamped=%0b, got steps=%0d clamped=%0b",
                     want.steps, want.clamped, steps, clamped);
          end
          err_cnt++;
        end
      end
    end
  end

  task automatic test_default_regs();
    send_lift(16'd0);
    send_lift(16'd1);
    send_lift(16'd101);
    send_lift(16'd102);
    send_lift(16'd1586);
    send_lift(16'd1587);
    send_lift(16'd1600);
    send_lift(16'd1601);
    send_lift(16'd65535);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    write_reg(rlts_pkg::CFG_MAX_LIFT, 24'h00FFFF);
    write_reg(rlts_pkg::CFG_MAX_STEPS, 24'hFFFFFF);
    write_reg(rlts_pkg::CFG_SPT, 24'h00FFFF);
    send_lift(16'd0);
    send_lift(16'd1586);
    send_lift(16'd1587);
    send_lift(16'd32768);
    send_lift(16'd65535);
    wait_drained();
    // zero steps per turn, upper data bits must be dropped
    write_reg(rlts_pkg::CFG_SPT, 24'hFF0000);
    send_lift(16'd500);
    send_lift(16'd1587);
    wait_drained();
    write_reg(rlts_pkg::CFG_SPT, 24'h000001);
    send_lift(16'd1585);
    wait_drained();
    write_reg(rlts_pkg::CFG_MAX_LIFT, 24'h000000);
    write_reg(rlts_pkg::CFG_MAX_STEPS, 24'h000000);
    send_lift(16'd0);
    send_lift(16'd1);
    wait_drained();
  endtask

  task automatic test_random_settings();
    logic [rlts_pkg::CFG_W-1:0] val;
    for (int unsigned phase = 0; phase < 7; phase++) begin
      if (phase == 0) begin
        write_reg(rlts_pkg::CFG_MAX_LIFT, rlts_pkg::CFG_W'(rlts_pkg::MAX_LIFT_RST));
        write_reg(rlts_pkg::CFG_MAX_STEPS, rlts_pkg::CFG_W'(rlts_pkg::MAX_STEPS_RST));
        write_reg(rlts_pkg::CFG_SPT, rlts_pkg::CFG_W'(rlts_pkg::SPT_RST));
      end else begin
        case ($urandom_range(0, 3))
          0:       val = rlts_pkg::CFG_W'($urandom_range(0, 65535));
          1:       val = rlts_pkg::CFG_W'(16'hFFFF);
          default: val = rlts_pkg::CFG_W'($urandom_range(1500, 1700));
        endcase
        if ($urandom_range(0, 3) == 0) begin
          val[rlts_pkg::CFG_W-1:rlts_pkg::LIFT_W] =
            (rlts_pkg::CFG_W - rlts_pkg::LIFT_W)'($urandom);
        end
        write_reg(rlts_pkg::CFG_MAX_LIFT, val);
        write_reg(rlts_pkg::CFG_MAX_STEPS, rlts_pkg::CFG_W'($urandom));
        if ($urandom_range(0, 19) == 0) begin
          val = '0;
        end else begin
          val = rlts_pkg::CFG_W'($urandom_range(1, 65535));
        end
        if ($urandom_range(0, 3) == 0) begin
          val[rlts_pkg::CFG_W-1:rlts_pkg::SPT_W] =
            (rlts_pkg::CFG_W - rlts_pkg::SPT_W)'($urandom);
        end
        write_reg(rlts_pkg::CFG_SPT, val);
      end
      for (int unsigned i = 0; i < 150; i++) begin
        if (i % 50 == 0) begin
          tx_idle = $urandom_range(0, 2) != 0;
          rx_idle = $urandom_range(0, 2) != 0;
        end
        send_lift(pick_lift());
      end
      wait_drained();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_output_backpressure();
    tx_idle = 1'b0;
    fork
      hold_output(400);
      begin
        repeat (30) send_lift(pick_lift());
      end
    join
    tx_idle = 1'b1;
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_regs();
    test_register_extremes();
    test_random_settings();
    test_output_backpressure();
    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
